@@ sv/mep_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the MIPS REL relocation patcher.
// No dependencies; imported by mep_cell and the top level.
package mep_pkg;

  // relocation type codes carried in the input tuser
  localparam logic [7:0] TYPE_NONE   = 8'd0;
  localparam logic [7:0] TYPE_ABS32  = 8'd2;
  localparam logic [7:0] TYPE_JUMP26 = 8'd4;
  localparam logic [7:0] TYPE_HI16   = 8'd5;
  localparam logic [7:0] TYPE_LO16   = 8'd6;

  // result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_UNALIGNED   = 3'd1;
  localparam logic [2:0] ST_REGION      = 3'd2;
  localparam logic [2:0] ST_FULL        = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

  localparam logic [31:0] REGION_MASK  = 32'hf000_0000;
  localparam logic [31:0] FIELD26_MASK = 32'h03ff_ffff;

  // one parked HI16: its address and the whole original word
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] word;
  } entry_t;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP
  } stk_op_t;

endpackage

@@ sv/mep_cell.sv @@
`timescale 1ns / 1ps
// One cell of the HI16 stack: holds a single parked entry.
// Depends on mep_pkg for entry_t and stk_op_t.
module mep_cell (
  input  logic             clk,
  input  mep_pkg::stk_op_t op,
  input  mep_pkg::entry_t  left_in,   // from the cell nearer the top
  input  mep_pkg::entry_t  right_in,  // from the cell further down
  output mep_pkg::entry_t  entry
);
  import mep_pkg::*;

  entry_t entry_r;

  // push moves everything one cell down, pop moves it one cell up
  always_ff @(posedge clk) begin
    case (op)
      STK_PUSH: entry_r <= left_in;
      STK_POP:  entry_r <= right_in;
      default:  entry_r <= entry_r;
    endcase
  end

  assign entry = entry_r;

endmodule

@@ sv/mips_elf_relocation_patcher_unit.sv @@
`timescale 1ns / 1ps
// Top level of the MIPS REL relocation patcher: stream ports, result register,
// LO16 drain sequencer and a row of mep_cell stack cells. Depends on mep_pkg.
//
// Each input beat is one relocation. NONE, ABS32, JUMP26, HI16 and unknown
// types each give one result beat. Unless the stack is full, a HI16 parks its
// address and word in a row of PENDING_DEPTH cells that shift as a stack,
// newest entry in the first cell. A LO16 is first captured, then gives one
// result beat per parked HI16 (popped from the first cell, newest first) and
// finally its own beat with tlast. Input is refused while a LO16 drains. A
// single result register sits on the output, so a new beat is taken in the
// same cycle the previous result is taken.
module mips_elf_relocation_patcher_unit #(
  parameter int PENDING_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // target_addr[31:0], target_word[63:32], sym_value[95:64]
  input  logic [7:0]  in_tuser,   // mode[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // patch_addr[31:0], patch_word[63:32]
  output logic [3:0]  out_tuser,  // write_enable[0], status[3:1]
  output logic        out_tlast
);
  import mep_pkg::*;

  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(PENDING_DEPTH);

  typedef enum logic {S_IDLE, S_DRAIN} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_addr_r, out_addr_nxt;
  logic [31:0]       out_word_r, out_word_nxt;
  logic              out_we_r, out_we_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;
  logic [31:0]       lo_addr_r, lo_addr_nxt;
  logic [31:0]       lo_word_r, lo_word_nxt;
  logic [31:0]       lo_sum_r, lo_sum_nxt;

  logic [7:0]  mode;
  logic [31:0] t_addr, t_word, sym;
  logic        slot_free, accept, full;
  stk_op_t     stk_op;
  entry_t      push_entry;
  entry_t      cell_q [PENDING_DEPTH];

  logic [31:0] lo_ext, addr_p4, j_word, hi_acc;
  logic [15:0] hi_half;

  assign mode   = in_tuser;
  assign t_addr = in_tdata[31:0];
  assign t_word = in_tdata[63:32];
  assign sym    = in_tdata[95:64];

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == FULL_CNT);

  assign lo_ext  = {{16{t_word[15]}}, t_word[15:0]};
  assign addr_p4 = t_addr + 32'd4;
  assign j_word  = (t_word & ~FIELD26_MASK) | ((t_word + {2'b00, sym[31:2]}) & FIELD26_MASK);

  // carry-adjusted high half of the entry at the top of the stack
  assign hi_acc  = {cell_q[0].word[15:0], 16'h0000} + lo_sum_r;
  assign hi_half = hi_acc[31:16] + {15'd0, hi_acc[15]};

  assign push_entry = '{addr: t_addr, word: t_word};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_addr_nxt   = out_addr_r;
    out_word_nxt   = out_word_r;
    out_we_nxt     = out_we_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    lo_addr_nxt    = lo_addr_r;
    lo_word_nxt    = lo_word_r;
    lo_sum_nxt     = lo_sum_r;
    stk_op         = STK_HOLD;

    if (accept) begin
      out_addr_nxt   = t_addr;
      out_word_nxt   = t_word;
      out_we_nxt     = 1'b0;
      out_status_nxt = ST_OK;
      out_last_nxt   = 1'b1;
      out_valid_nxt  = 1'b1;
      case (mode)
        TYPE_NONE: ;
        TYPE_ABS32: begin
          out_word_nxt = t_word + sym;
          out_we_nxt   = 1'b1;
        end
        TYPE_JUMP26: begin
          if (sym[1:0] != 2'b00) begin
            out_status_nxt = ST_UNALIGNED;
          end else if ((sym & REGION_MASK) != (addr_p4 & REGION_MASK)) begin
            out_status_nxt = ST_REGION;
          end else begin
            out_word_nxt = j_word;
            out_we_nxt   = 1'b1;
          end
        end
        TYPE_HI16: begin
          if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            stk_op    = STK_PUSH;
            count_nxt = count_r + 1'b1;
          end
        end
        TYPE_LO16: begin
          // hold the LO16 and emit nothing until the stack is drained
          out_valid_nxt = 1'b0;
          lo_addr_nxt   = t_addr;
          lo_word_nxt   = t_word;
          lo_sum_nxt    = lo_ext + sym;
          state_nxt     = S_DRAIN;
        end
        default: out_status_nxt = ST_UNSUPPORTED;
      endcase
    end else if (state_r == S_DRAIN && slot_free) begin
      out_valid_nxt  = 1'b1;
      out_we_nxt     = 1'b1;
      out_status_nxt = ST_OK;
      if (count_r != '0) begin
        out_addr_nxt = cell_q[0].addr;
        out_word_nxt = {cell_q[0].word[31:16], hi_half};
        out_last_nxt = 1'b0;
        stk_op       = STK_POP;
        count_nxt    = count_r - 1'b1;
      end else begin
        out_addr_nxt = lo_addr_r;
        out_word_nxt = {lo_word_r[31:16], lo_sum_r[15:0]};
        out_last_nxt = 1'b1;
        state_nxt    = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_addr_r   <= out_addr_nxt;
    out_word_r   <= out_word_nxt;
    out_we_r     <= out_we_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    lo_addr_r    <= lo_addr_nxt;
    lo_word_r    <= lo_word_nxt;
    lo_sum_r     <= lo_sum_nxt;
  end

  for (genvar g = 0; g < PENDING_DEPTH; g++) begin : g_cell
    entry_t left_in, right_in;
    if (g == 0) begin : g_first
      assign left_in = push_entry;
    end else begin : g_mid
      assign left_in = cell_q[g-1];
    end
    if (g == PENDING_DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_body
      assign right_in = cell_q[g+1];
    end
    mep_cell u_cell (
      .clk      (clk),
      .op       (stk_op),
      .left_in  (left_in),
      .right_in (right_in),
      .entry    (cell_q[g])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_word_r, out_addr_r};
  assign out_tuser  = {out_status_r, out_we_r};
  assign out_tlast  = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("stack count beyond depth");

  a_mid_beat_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_we_r && out_status_r == ST_OK)
    else $error("non-final beat must be a HI16 patch");

  a_pop_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    stk_op == STK_POP |-> state_r == S_DRAIN && count_r != '0)
    else $error("pop outside drain or on empty stack");

  a_no_input_drain: assert property (@(posedge clk) disable iff (!rst_n)
    accept && mode == TYPE_LO16 |=> state_r == S_DRAIN && !in_tready)
    else $error("LO16 did not enter drain");

endmodule
